FILE: sv/cldt_pkg.sv
// Shared types and codes for the camera link detect and trigger block.
package cldt_pkg;

  localparam int unsigned REG_W = 16;
  localparam int unsigned IDX_W = 8;

  localparam logic [IDX_W-1:0] REG_STATUS_INTERVAL = 8'd0;
  localparam logic [IDX_W-1:0] REG_FOCUS_PULSE     = 8'd1;
  localparam logic [IDX_W-1:0] REG_SHUTTER_PULSE   = 8'd2;
  localparam logic [IDX_W-1:0] REG_LOSS_MARGIN     = 8'd3;

  localparam logic [REG_W-1:0] STATUS_INTERVAL_RST = 16'd100;
  localparam logic [REG_W-1:0] FOCUS_PULSE_RST     = 16'd500;
  localparam logic [REG_W-1:0] SHUTTER_PULSE_RST   = 16'd500;
  localparam logic [REG_W-1:0] LOSS_MARGIN_RST     = 16'd500;

  localparam logic [1:0] LINK_NONE  = 2'd0;
  localparam logic [1:0] LINK_CABLE = 2'd1;
  localparam logic [1:0] LINK_FULL  = 2'd2;

  localparam logic [1:0] BEEP_NONE  = 2'd0;
  localparam logic [1:0] BEEP_FOUND = 2'd1;
  localparam logic [1:0] BEEP_LOST  = 2'd2;

  typedef enum logic [2:0] {
    TRIG_IDLE    = 3'b001,
    TRIG_FOCUS   = 3'b010,
    TRIG_SHUTTER = 3'b100
  } trig_state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] beep;
  } link_res_t;

  typedef struct packed {
    logic focus;
    logic shutter;
    logic busy;
  } trig_res_t;

endpackage

FILE: sv/cldt_link.sv
// Cable and camera detection with loss timing and link status.
module cldt_link #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         sample,
  input  logic                         cable,
  input  logic                         cam,
  input  logic [cldt_pkg::REG_W-1:0]   shutter_len,
  input  logic [cldt_pkg::REG_W-1:0]   margin,
  output cldt_pkg::link_res_t          res
);

  localparam int unsigned LW   = TIME_WIDTH + 1;
  localparam int unsigned CMPW = (LW > cldt_pkg::REG_W + 1) ? LW : cldt_pkg::REG_W + 1;

  logic [1:0]    status;
  logic          plugged;
  logic          present;
  logic          prev;
  logic          timing;
  logic [LW-1:0] elapsed;

  logic [1:0]    status_next;
  logic          plugged_next;
  logic          present_next;
  logic          prev_next;
  logic          timing_next;
  logic [LW-1:0] elapsed_next;
  logic [1:0]    beep;

  logic [LW-1:0]   elapsed_inc;
  logic [CMPW-1:0] thresh;
  logic            expired;

  assign elapsed_inc = timing ? ((elapsed == '1) ? elapsed : elapsed + 1'b1) : elapsed;
  assign thresh  = CMPW'({1'b0, shutter_len} + {1'b0, margin});
  assign expired = CMPW'(elapsed_inc) >= thresh;

  always_comb begin
    plugged_next = plugged;
    present_next = present;
    prev_next    = prev;
    timing_next  = timing;
    elapsed_next = elapsed_inc;
    status_next  = status;
    beep         = cldt_pkg::BEEP_NONE;
    if (sample) begin
      if (prev && !cable) begin
        plugged_next = 1'b1;
      end else if (!prev && cable) begin
        plugged_next = 1'b0;
        present_next = 1'b0;
      end
      prev_next = cable;
      if (!plugged_next) begin
        present_next = 1'b0;
        timing_next  = 1'b0;
        elapsed_next = '0;
      end else if (cam && !present_next) begin
        present_next = 1'b1;
        timing_next  = 1'b0;
        elapsed_next = '0;
        beep         = cldt_pkg::BEEP_FOUND;
      end else if (!cam && present_next) begin
        // start timing at the first low sample, judge only at later ones
        if (!timing) begin
          timing_next  = 1'b1;
          elapsed_next = '0;
        end else if (expired) begin
          present_next = 1'b0;
          timing_next  = 1'b0;
          elapsed_next = '0;
          beep         = cldt_pkg::BEEP_LOST;
        end
      end else if (cam && timing) begin
        timing_next  = 1'b0;
        elapsed_next = '0;
      end
      if (!plugged_next) begin
        status_next = cldt_pkg::LINK_NONE;
      end else if (!present_next) begin
        status_next = cldt_pkg::LINK_CABLE;
      end else begin
        status_next = cldt_pkg::LINK_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status  <= cldt_pkg::LINK_NONE;
      plugged <= 1'b0;
      present <= 1'b0;
      prev    <= 1'b1;
      timing  <= 1'b0;
      elapsed <= '0;
    end else if (accept) begin
      status  <= status_next;
      plugged <= plugged_next;
      present <= present_next;
      prev    <= prev_next;
      timing  <= timing_next;
      elapsed <= elapsed_next;
    end
  end

  assign res.status = status_next;
  assign res.beep   = beep;

endmodule

FILE: sv/cldt_trigger.sv
// Focus and shutter pulse timing.
module cldt_trigger #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [1:0]                   status,
  input  logic                         focus_req,
  input  logic                         shutter_req,
  input  logic [cldt_pkg::REG_W-1:0]   focus_len,
  input  logic [cldt_pkg::REG_W-1:0]   shutter_len,
  output cldt_pkg::trig_res_t          res
);

  localparam int unsigned CMPW = (TIME_WIDTH > cldt_pkg::REG_W) ? TIME_WIDTH : cldt_pkg::REG_W;

  cldt_pkg::trig_state_t state, state_next, state_mid;
  logic [TIME_WIDTH-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [cldt_pkg::REG_W-1:0] len;
  logic                       done;

  always_comb begin
    elapsed_inc = elapsed;
    len         = shutter_len;
    unique case (state)
      cldt_pkg::TRIG_IDLE: begin
        elapsed_inc = elapsed;
      end
      cldt_pkg::TRIG_FOCUS: begin
        elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
        len         = focus_len;
      end
      cldt_pkg::TRIG_SHUTTER: begin
        elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
      end
      default: begin
        elapsed_inc = elapsed;
      end
    endcase
  end

  assign done = (state != cldt_pkg::TRIG_IDLE) && (CMPW'(elapsed_inc) >= CMPW'(len));

  always_comb begin
    state_mid    = done ? cldt_pkg::TRIG_IDLE : state;
    elapsed_next = done ? '0 : elapsed_inc;
    state_next   = state_mid;
    // focus wins over shutter
    if (state_mid == cldt_pkg::TRIG_IDLE && status == cldt_pkg::LINK_FULL) begin
      if (focus_req) begin
        state_next   = cldt_pkg::TRIG_FOCUS;
        elapsed_next = '0;
      end else if (shutter_req) begin
        state_next   = cldt_pkg::TRIG_SHUTTER;
        elapsed_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cldt_pkg::TRIG_IDLE;
      elapsed <= '0;
    end else if (accept) begin
      state   <= state_next;
      elapsed <= elapsed_next;
    end
  end

  assign res.focus   = (state_next == cldt_pkg::TRIG_FOCUS);
  assign res.shutter = (state_next == cldt_pkg::TRIG_SHUTTER);
  assign res.busy    = (state_next != cldt_pkg::TRIG_IDLE);

endmodule

FILE: sv/camera_link_detect_and_trigger.sv
// Top level: configuration, status interval counter and result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | to block  | in_valid/in_stall  | cable/camera levels, focus/shutter request
//   out     | from block| out_valid/out_stall| link status, drives, busy, beep
//   cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per clock unless stalled; its result enters the result register next cycle.
// The state update for an item is a single pass through the detect and trigger logic.
// Reset restores register defaults and clears all detection and pulse state.
// A stalled, full result register holds the next item off; otherwise it is taken at once.
module camera_link_detect_and_trigger #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cable_sense_level,
  input  logic                         camera_sense_level,
  input  logic                         focus_request,
  input  logic                         shutter_request,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   link_status,
  output logic                         focus_drive,
  output logic                         shutter_drive,
  output logic                         trigger_busy,
  output logic [1:0]                   beep_event,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cldt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cldt_pkg::REG_W-1:0]   cfg_data
);

  localparam int unsigned CMPW = (TIME_WIDTH > cldt_pkg::REG_W) ? TIME_WIDTH : cldt_pkg::REG_W;

  logic [cldt_pkg::REG_W-1:0] status_interval;
  logic [cldt_pkg::REG_W-1:0] focus_pulse;
  logic [cldt_pkg::REG_W-1:0] shutter_pulse;
  logic [cldt_pkg::REG_W-1:0] loss_margin;

  logic [TIME_WIDTH-1:0] check;
  logic [TIME_WIDTH-1:0] check_inc;
  logic [TIME_WIDTH-1:0] check_next;
  logic                  sample;
  logic                  accept;

  cldt_pkg::link_res_t link_res;
  cldt_pkg::trig_res_t trig_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      status_interval <= cldt_pkg::STATUS_INTERVAL_RST;
      focus_pulse     <= cldt_pkg::FOCUS_PULSE_RST;
      shutter_pulse   <= cldt_pkg::SHUTTER_PULSE_RST;
      loss_margin     <= cldt_pkg::LOSS_MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cldt_pkg::REG_STATUS_INTERVAL: status_interval <= cfg_data;
        cldt_pkg::REG_FOCUS_PULSE:     focus_pulse     <= cfg_data;
        cldt_pkg::REG_SHUTTER_PULSE:   shutter_pulse   <= cfg_data;
        cldt_pkg::REG_LOSS_MARGIN:     loss_margin     <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the interval counter, then sample once it reaches the interval
  assign check_inc  = (check == '1) ? check : check + 1'b1;
  assign sample     = CMPW'(check_inc) >= CMPW'(status_interval);
  assign check_next = sample ? '0 : check_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      check <= '0;
    end else if (accept) begin
      check <= check_next;
    end
  end

  cldt_link #(.TIME_WIDTH(TIME_WIDTH)) u_link (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sample      (sample),
    .cable       (cable_sense_level),
    .cam         (camera_sense_level),
    .shutter_len (shutter_pulse),
    .margin      (loss_margin),
    .res         (link_res)
  );

  cldt_trigger #(.TIME_WIDTH(TIME_WIDTH)) u_trigger (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .status      (link_res.status),
    .focus_req   (focus_request),
    .shutter_req (shutter_request),
    .focus_len   (focus_pulse),
    .shutter_len (shutter_pulse),
    .res         (trig_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      link_status   <= link_res.status;
      focus_drive   <= trig_res.focus;
      shutter_drive <= trig_res.shutter;
      trigger_busy  <= trig_res.busy;
      beep_event    <= link_res.beep;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  a_busy_matches_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (trigger_busy == (focus_drive || shutter_drive)) &&
                  !(focus_drive && shutter_drive))
    else $error("trigger busy inconsistent with drives");

  a_found_is_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && beep_event == cldt_pkg::BEEP_FOUND |-> link_status == cldt_pkg::LINK_FULL)
    else $error("camera found beep without full link");

  a_lost_is_cable: assert property (@(posedge clk) disable iff (rst)
    out_valid && beep_event == cldt_pkg::BEEP_LOST |-> link_status == cldt_pkg::LINK_CABLE)
    else $error("camera lost beep with wrong link status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (link_status <= cldt_pkg::LINK_FULL) && (beep_event <= cldt_pkg::BEEP_LOST))
    else $error("unused status or beep code");

endmodule
